// ----- rtl/core/ems_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and slot tables for the elapsed-time text block.
// No dependencies.
package ems_pkg;

    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_COLON = 6'd58;
    localparam logic [5:0] CH_APOS  = 6'd39;

    localparam logic MODE_HMS = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_COLON = 2'd1;
    localparam logic [1:0] KIND_APOS  = 2'd2;

    // One queued item: text mode plus elapsed tick count (masked to the tick width)
    typedef struct packed {
        logic        mode;
        logic [31:0] elapsed;
    } item_t;

    // Mode 0 slots: H H H H : M M : S S : C C '   Mode 1 slots: ten decimal digits
    function automatic logic [1:0] slot_kind(input logic mode, input logic [3:0] slot);
        logic [1:0] k;
        k = KIND_DIGIT;
        if (mode == MODE_HMS) begin
            case (slot)
                4'd4, 4'd7, 4'd10: k = KIND_COLON;
                4'd13:             k = KIND_APOS;
                default:           k = KIND_DIGIT;
            endcase
        end
        return k;
    endfunction

    function automatic logic [31:0] slot_weight(input logic mode, input logic [3:0] slot);
        logic [31:0] w;
        w = 32'd1;
        if (mode == MODE_HMS) begin
            case (slot)
                4'd0:    w = 32'd3600000000;
                4'd1:    w = 32'd360000000;
                4'd2:    w = 32'd36000000;
                4'd3:    w = 32'd3600000;
                4'd5:    w = 32'd600000;
                4'd6:    w = 32'd60000;
                4'd8:    w = 32'd10000;
                4'd9:    w = 32'd1000;
                4'd11:   w = 32'd100;
                4'd12:   w = 32'd10;
                default: w = 32'd1;
            endcase
        end else begin
            case (slot)
                4'd0:    w = 32'd1000000000;
                4'd1:    w = 32'd100000000;
                4'd2:    w = 32'd10000000;
                4'd3:    w = 32'd1000000;
                4'd4:    w = 32'd100000;
                4'd5:    w = 32'd10000;
                4'd6:    w = 32'd1000;
                4'd7:    w = 32'd100;
                4'd8:    w = 32'd10;
                default: w = 32'd1;
            endcase
        end
        return w;
    endfunction

    // Leading zero may be dropped (upper two hour digits, or all but the units digit)
    function automatic logic slot_blankable(input logic mode, input logic [3:0] slot);
        return (mode == MODE_HMS) ? (slot < 4'd2) : (slot < 4'd9);
    endfunction

    function automatic logic slot_is_last(input logic mode, input logic [3:0] slot);
        return (mode == MODE_HMS) ? (slot == 4'd13) : (slot == 4'd9);
    endfunction

endpackage

// ----- rtl/core/ems_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input transactions, forms the wrapped elapsed count, and
// holds items in a two-entry queue for the back end. Uses ems_pkg.
module ems_front #(
    parameter int TICK_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,   // [31:0] now_ms, [63:32] offset_ms
    input  logic [0:0]     s_axis_tuser,   // [0] mode
    output logic           q_valid,
    output ems_pkg::item_t q_item,
    input  logic           q_pop
);
    import ems_pkg::*;

    localparam int EW = (TICK_WIDTH > 32) ? 32 : ((TICK_WIDTH < 1) ? 1 : TICK_WIDTH);
    localparam logic [31:0] TICK_MASK = 32'hFFFF_FFFF >> (32 - EW);

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    item_t       in_item;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.mode    = s_axis_tuser[0];
        in_item.elapsed = (s_axis_tdata[31:0] - s_axis_tdata[63:32]) & TICK_MASK;
        wr_ptr_next     = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next     = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next      = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/core/ems_back.sv -----
`timescale 1ns / 1ps
// Back end: digit sequencer (one compare-subtract per cycle, four per digit)
// and output register. Uses ems_pkg.
module ems_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ems_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,   // [5:0] char_code, [7:6] zero
    output logic           m_axis_tlast    // last
);
    import ems_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIGIT = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [31:0] rem_reg, rem_next;
    logic [3:0]  slot_reg, slot_next;
    logic [1:0]  bit_reg, bit_next;
    logic [3:0]  digit_reg, digit_next;
    logic        started_reg, started_next;
    logic        ovalid_reg, ovalid_next;
    logic [5:0]  ochar_reg, ochar_next;
    logic        olast_reg, olast_next;

    logic        out_free;
    logic [35:0] trial;
    logic        fits;
    logic [3:0]  digit_fin;
    logic [1:0]  kind;
    logic [3:0]  slot_inc;
    logic [5:0]  char_now;

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, ochar_reg};
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        kind     = slot_kind(mode_reg, slot_reg);
        slot_inc = slot_reg + 4'd1;
        trial    = {4'd0, rem_reg} - ({4'd0, slot_weight(mode_reg, slot_reg)} << bit_reg);
        fits     = !trial[35];
        digit_fin = digit_reg | {3'd0, fits};
        case (kind)
            KIND_COLON: char_now = CH_COLON;
            KIND_APOS:  char_now = CH_APOS;
            default:    char_now = CH_ZERO + {2'b00, digit_reg};
        endcase

        state_next   = state_reg;
        mode_next    = mode_reg;
        rem_next     = rem_reg;
        slot_next    = slot_reg;
        bit_next     = bit_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        q_pop        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    // first slot is a digit in both modes
                    q_pop        = 1'b1;
                    mode_next    = q_item.mode;
                    rem_next     = q_item.elapsed;
                    slot_next    = 4'd0;
                    bit_next     = 2'd3;
                    digit_next   = 4'd0;
                    started_next = 1'b0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (fits)
                begin
                    rem_next = trial[31:0];
                end
                bit_next = bit_reg - 2'd1;
                if (bit_reg == 2'd0)
                begin
                    digit_next = digit_fin;
                    if (slot_blankable(mode_reg, slot_reg) && !started_reg
                        && digit_fin == 4'd0)
                    begin
                        // leading zero dropped; next slot is again a digit
                        slot_next  = slot_inc;
                        bit_next   = 2'd3;
                        digit_next = 4'd0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    digit_next = fits ? (digit_reg | (4'd1 << bit_reg)) : digit_reg;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    ochar_next   = char_now;
                    olast_next   = slot_is_last(mode_reg, slot_reg);
                    started_next = 1'b1;
                    if (slot_is_last(mode_reg, slot_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_inc;
                        bit_next   = 2'd3;
                        digit_next = 4'd0;
                        state_next = (slot_kind(mode_reg, slot_inc) == KIND_DIGIT)
                                     ? ST_DIGIT : ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        rem_reg   <= rem_next;
        slot_reg  <= slot_next;
        bit_reg   <= bit_next;
        digit_reg <= digit_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

// ----- rtl/core/elapsed_ms_to_decimal_time_text.sv -----
`timescale 1ns / 1ps
// Elapsed-time text: (now - offset) as HHHH:MM:SS:CC' or plain decimal, one char per beat.
// Each digit is found by compare-subtract against its place weight and then emitted;
// punctuation is emitted directly, and dropped leading zeros are not emitted.
// A two-entry queue lets the next item wait while the current one is converted.
// rst_n (async, low) empties the queue and clears the sequencer and output valid.
module elapsed_ms_to_decimal_time_text #(
    parameter int TICK_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] now_ms, [63:32] offset_ms
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] char_code, [7:6] zero
    output logic        m_axis_tlast    // last
);
    import ems_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    ems_front #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    ems_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/core/ems_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the elapsed-time text block, bound to the top level.
// Depends only on the top-level ports.
module ems_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // output register is cleared asynchronously by reset, so check in the cycle after
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00 &&
            ((m_axis_tdata[5:0] >= 6'd48 && m_axis_tdata[5:0] <= 6'd58)
             || m_axis_tdata[5:0] == 6'd39))
        else $error("character outside digit, colon, apostrophe");

    a_last_not_colon: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] != 6'd58)
        else $error("text ends on a colon");

    a_apos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:0] == 6'd39 |-> m_axis_tlast)
        else $error("apostrophe not on final character");

endmodule

bind elapsed_ms_to_decimal_time_text ems_checker u_ems_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
